FILE: hw/rtl/sbph_pkg.sv
// Shared types and constants for the spectrum band peak-hold block.
package sbph_pkg;

   localparam int ACTION_W   = 2;
   localparam int IDX_W      = 9;
   localparam int MAG_W      = 20;
   localparam int SUM_W      = 29;
   localparam int LEVEL_W    = 16;
   localparam int DECAY_W    = 16;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 29;
   localparam int NUM_BANDS  = 3;

   localparam logic [SUM_W-1:0]   LOW_THR_RESET  = 29'd35000;
   localparam logic [SUM_W-1:0]   HIGH_THR_RESET = 29'd200000;
   localparam logic [DECAY_W-1:0] DECAY_RESET    = 16'd25;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX      = 16'd65535;

   // sums at or above this give a quotient beyond full scale
   localparam logic [SUM_W-1:0] DIV3_SAT_SUM = 29'd196608;
   localparam int               DIV3_IN_W    = 18;
   localparam int               DIV3_SHIFT   = 19;
   localparam logic [DIV3_IN_W-1:0] DIV3_RECIP = 18'd174763;

   typedef enum logic [ACTION_W-1:0] {
      ACT_BIN    = 2'd0,
      ACT_UPDATE = 2'd1,
      ACT_DECAY  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      BAND_RED   = 2'd0,
      BAND_GREEN = 2'd1,
      BAND_BLUE  = 2'd2
   } band_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_LOW_THR  = 2'd0,
      CSR_HIGH_THR = 2'd1,
      CSR_DECAY    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic             take;
      logic [IDX_W-1:0] bin_index;
      logic [MAG_W-1:0] magnitude;
   } bin_cmd_type;

endpackage

FILE: hw/rtl/sbph_band_accum.sv
// Band accumulators and latched band sums, updated one bin item per cycle.
module sbph_band_accum #(
   parameter int NUM_BINS = 512,
   parameter int MAG_BITS = 20
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  sbph_pkg::bin_cmd_type                              cmd,
   output logic [sbph_pkg::NUM_BANDS-1:0][sbph_pkg::SUM_W-1:0] band_sums
);
   import sbph_pkg::*;

   localparam int CMP_W   = ($clog2(NUM_BINS) + 1 > IDX_W) ? $clog2(NUM_BINS) + 1 : IDX_W;
   localparam int MAG_USE = (MAG_BITS < MAG_W) ? MAG_BITS : MAG_W;
   localparam logic [MAG_W-1:0] MAG_MASK =
      MAG_W'((({(MAG_W+1){1'b0}} | (MAG_W+1)'(1)) << MAG_USE) - (MAG_W+1)'(1));
   localparam logic [CMP_W-1:0] BINS_C  = CMP_W'(NUM_BINS);
   localparam logic [CMP_W-1:0] LOW_END = CMP_W'(NUM_BINS / 4);
   localparam logic [CMP_W-1:0] MID_END = CMP_W'(NUM_BINS - NUM_BINS / 4);
   localparam logic [CMP_W-1:0] LAST_C  = CMP_W'(NUM_BINS - 1);

   logic [NUM_BANDS-1:0][SUM_W-1:0] acc_ff, acc_in;
   logic [NUM_BANDS-1:0][SUM_W-1:0] sums_ff, sums_in;
   logic [CMP_W-1:0]                idx_ext;
   band_type                        band;
   logic [SUM_W:0]                  total;

   always_comb begin
      acc_in  = acc_ff;
      sums_in = sums_ff;
      idx_ext = CMP_W'(cmd.bin_index);
      if (idx_ext < LOW_END) begin
         band = BAND_RED;
      end else if (idx_ext < MID_END) begin
         band = BAND_GREEN;
      end else begin
         band = BAND_BLUE;
      end
      total = '0;
      if (cmd.take && (idx_ext < BINS_C)) begin
         if (idx_ext == '0) begin
            acc_in = '0;
         end
         total = {1'b0, acc_in[band]} + (SUM_W+1)'(cmd.magnitude & MAG_MASK);
         acc_in[band] = total[SUM_W] ? {SUM_W{1'b1}} : total[SUM_W-1:0];
         if (idx_ext == LAST_C) begin
            sums_in = acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         sums_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         sums_ff <= sums_in;
      end
   end

   assign band_sums = sums_ff;

endmodule

FILE: hw/rtl/sbph_level_map.sv
// Maps one latched band sum to a 16-bit level through the two thresholds and a saturating divide by three.
module sbph_level_map (
   input  logic [sbph_pkg::SUM_W-1:0]   band_sum,
   input  logic [sbph_pkg::SUM_W-1:0]   low_thr,
   input  logic [sbph_pkg::SUM_W-1:0]   high_thr,
   output logic [sbph_pkg::LEVEL_W-1:0] level
);
   import sbph_pkg::*;

   logic [2*DIV3_IN_W-1:0] prod;

   assign prod = (2*DIV3_IN_W)'(band_sum[DIV3_IN_W-1:0]) * (2*DIV3_IN_W)'(DIV3_RECIP);

   always_comb begin
      if (band_sum < low_thr) begin
         level = '0;
      end else if (band_sum > high_thr) begin
         level = LEVEL_MAX;
      end else if (band_sum >= DIV3_SAT_SUM) begin
         level = LEVEL_MAX;
      end else begin
         level = prod[DIV3_SHIFT+LEVEL_W-1:DIV3_SHIFT];
      end
   end

endmodule

FILE: hw/rtl/spectrum_band_peak_hold_leds.sv
// Top level: spectrum band sums mapped to peak-held red, green and blue levels.
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle unless a stalled result backs up into req_stall.
// An input register and a result register separate the two channels.
// Reset (synchronous, active high) clears accumulators, sums, held levels and valids,
// and loads the threshold and decay registers with their default values.
module spectrum_band_peak_hold_leds #(
   parameter int NUM_BINS = 512,
   parameter int MAG_BITS = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sbph_pkg::ACTION_W-1:0]     req_action,
   input  logic [sbph_pkg::IDX_W-1:0]        req_bin_index,
   input  logic [sbph_pkg::MAG_W-1:0]        req_magnitude,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sbph_pkg::LEVEL_W-1:0]      rsp_red_level,
   output logic [sbph_pkg::LEVEL_W-1:0]      rsp_green_level,
   output logic [sbph_pkg::LEVEL_W-1:0]      rsp_blue_level,
   input  logic                              csr_we,
   input  logic [sbph_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [sbph_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import sbph_pkg::*;

   logic [SUM_W-1:0]   low_thr_ff;
   logic [SUM_W-1:0]   high_thr_ff;
   logic [DECAY_W-1:0] decay_ff;

   logic                in_valid_ff;
   logic [ACTION_W-1:0] in_action_ff;
   logic [IDX_W-1:0]    in_idx_ff;
   logic [MAG_W-1:0]    in_mag_ff;

   logic                              out_valid_ff;
   logic [NUM_BANDS-1:0][LEVEL_W-1:0] held_ff, held_in;
   logic [NUM_BANDS-1:0][SUM_W-1:0]   band_sums;
   logic [NUM_BANDS-1:0][LEVEL_W-1:0] new_level;

   logic        out_ready;
   logic        advance;
   logic        in_load;
   bin_cmd_type cmd;

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign in_load   = !in_valid_ff || out_ready;
   assign req_stall = !in_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_thr_ff  <= LOW_THR_RESET;
         high_thr_ff <= HIGH_THR_RESET;
         decay_ff    <= DECAY_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_LOW_THR:  low_thr_ff  <= csr_wdata;
            CSR_HIGH_THR: high_thr_ff <= csr_wdata;
            CSR_DECAY:    decay_ff    <= csr_wdata[DECAY_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_action_ff <= req_action;
         in_idx_ff    <= req_bin_index;
         in_mag_ff    <= req_magnitude;
      end
   end

   assign cmd.take      = advance && (in_action_ff == ACT_BIN);
   assign cmd.bin_index = in_idx_ff;
   assign cmd.magnitude = in_mag_ff;

   sbph_band_accum #(
      .NUM_BINS (NUM_BINS),
      .MAG_BITS (MAG_BITS)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .band_sums (band_sums)
   );

   for (genvar b = 0; b < NUM_BANDS; b++) begin : g_map
      sbph_level_map u_map (
         .band_sum (band_sums[b]),
         .low_thr  (low_thr_ff),
         .high_thr (high_thr_ff),
         .level    (new_level[b])
      );
   end

   always_comb begin
      held_in = held_ff;
      if (advance) begin
         unique case (action_type'(in_action_ff))
            ACT_UPDATE: begin
               for (int b = 0; b < NUM_BANDS; b++) begin
                  if (new_level[b] > held_ff[b]) begin
                     held_in[b] = new_level[b];
                  end
               end
            end
            ACT_DECAY: begin
               for (int b = 0; b < NUM_BANDS; b++) begin
                  held_in[b] = (held_ff[b] > decay_ff) ? held_ff[b] - decay_ff : '0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         held_ff      <= '0;
      end else begin
         held_ff <= held_in;
         if (out_ready) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   // hold the shown levels while the result waits
   logic [NUM_BANDS-1:0][LEVEL_W-1:0] shown_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         shown_ff <= held_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_red_level   = shown_ff[BAND_RED];
   assign rsp_green_level = shown_ff[BAND_GREEN];
   assign rsp_blue_level  = shown_ff[BAND_BLUE];

endmodule

FILE: hw/rtl/sbph_checker.sv
// Port-level checks for the spectrum band peak-hold block, bound to the top level.
module sbph_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [sbph_pkg::LEVEL_W-1:0] rsp_red_level,
   input logic [sbph_pkg::LEVEL_W-1:0] rsp_green_level,
   input logic [sbph_pkg::LEVEL_W-1:0] rsp_blue_level
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("valid or stall set after reset");

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while result side is free");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_red_level)
         && $stable(rsp_green_level) && $stable(rsp_blue_level))
      else $error("stalled result changed");

   a_item_delivered: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !(rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("accepted item did not reach the result register");

endmodule

bind spectrum_band_peak_hold_leds sbph_checker u_sbph_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_red_level   (rsp_red_level),
   .rsp_green_level (rsp_green_level),
   .rsp_blue_level  (rsp_blue_level)
);
